// ----- rtl/urtb_pkg.sv -----
`timescale 1ns / 1ps
// urtb_pkg: shared constants, command and status codes, ring index helpers
// used by every file of the serial port ring buffer block; no dependencies
package urtb_pkg;

  localparam int TX_DEPTH    = 16;
  localparam int RX_DEPTH    = 16;
  localparam int TX_PW       = $clog2(TX_DEPTH) + 1;
  localparam int RX_PW       = $clog2(RX_DEPTH) + 1;
  localparam int TX_SW       = $clog2(TX_DEPTH);
  localparam int RX_SW       = $clog2(RX_DEPTH);
  localparam int TX_SPARE    = 2;
  localparam int LVL_W       = 5;
  localparam int CMD_W       = 3;
  localparam int DATA_W      = 8;
  localparam int STAT_W      = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_PUT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RECV   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TXDONE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_TX_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RX_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RX_OVF  = 2'd3;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_GET,
    OP_RECV,
    OP_TXDONE,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] data;
  } item_t;

  typedef logic [TX_PW-1:0] tx_idx_t;
  typedef logic [RX_PW-1:0] rx_idx_t;

  function automatic tx_idx_t tx_inc(input tx_idx_t idx);
    return (idx == TX_PW'(2 * TX_DEPTH - 1)) ? '0 : idx + TX_PW'(1);
  endfunction

  function automatic rx_idx_t rx_inc(input rx_idx_t idx);
    return (idx == RX_PW'(2 * RX_DEPTH - 1)) ? '0 : idx + RX_PW'(1);
  endfunction

  function automatic logic [TX_SW-1:0] tx_slot(input tx_idx_t idx);
    tx_idx_t s;
    s = (idx >= TX_PW'(TX_DEPTH)) ? idx - TX_PW'(TX_DEPTH) : idx;
    return s[TX_SW-1:0];
  endfunction

  function automatic logic [RX_SW-1:0] rx_slot(input rx_idx_t idx);
    rx_idx_t s;
    s = (idx >= RX_PW'(RX_DEPTH)) ? idx - RX_PW'(RX_DEPTH) : idx;
    return s[RX_SW-1:0];
  endfunction

  function automatic logic [TX_PW:0] tx_count(input tx_idx_t w, input tx_idx_t r);
    logic [TX_PW:0] c;
    if (w >= r) begin
      c = {1'b0, w} - {1'b0, r};
    end else begin
      c = {1'b0, w} + (TX_PW + 1)'(2 * TX_DEPTH) - {1'b0, r};
    end
    return c;
  endfunction

  function automatic logic [RX_PW:0] rx_count(input rx_idx_t w, input rx_idx_t r);
    logic [RX_PW:0] c;
    if (w >= r) begin
      c = {1'b0, w} - {1'b0, r};
    end else begin
      c = {1'b0, w} + (RX_PW + 1)'(2 * RX_DEPTH) - {1'b0, r};
    end
    return c;
  endfunction

endpackage

// ----- rtl/urtb_ifs.sv -----
`timescale 1ns / 1ps
// urtb_in_if, urtb_out_if: valid/ready channels for requests and results
// depends on urtb_pkg for field widths
interface urtb_in_if;
  logic                          valid;
  logic                          ready;
  logic [urtb_pkg::CMD_W-1:0]    command;
  logic [urtb_pkg::DATA_W-1:0]   data_in;

  modport source (output valid, output command, output data_in, input ready);
  modport sink   (input valid, input command, input data_in, output ready);
endinterface

interface urtb_out_if;
  logic                          valid;
  logic                          ready;
  logic [urtb_pkg::STAT_W-1:0]   status;
  logic [urtb_pkg::DATA_W-1:0]   read_data;
  logic                          send_valid;
  logic [urtb_pkg::DATA_W-1:0]   send_byte;
  logic [urtb_pkg::LVL_W-1:0]    tx_level;
  logic [urtb_pkg::LVL_W-1:0]    rx_level;

  modport source (output valid, output status, output read_data, output send_valid,
                  output send_byte, output tx_level, output rx_level, input ready);
  modport sink   (input valid, input status, input read_data, input send_valid,
                  input send_byte, input tx_level, input rx_level, output ready);
endinterface

// ----- rtl/urtb_front.sv -----
`timescale 1ns / 1ps
// urtb_front: accepts requests and decodes the command into an operation
// depends on urtb_pkg and urtb_ifs
module urtb_front (
  input  logic            clk,
  input  logic            rst_n,
  urtb_in_if.sink         in_ch,
  output urtb_pkg::item_t push_item,
  output logic            push_valid,
  input  logic            push_ready
);
  import urtb_pkg::*;

  logic  hold_valid_r;
  item_t hold_item_r;
  logic  in_fire;
  op_t   op_dec;

  always_comb begin
    unique case (in_ch.command)
      CMD_PUT:    op_dec = OP_PUT;
      CMD_GET:    op_dec = OP_GET;
      CMD_RECV:   op_dec = OP_RECV;
      CMD_TXDONE: op_dec = OP_TXDONE;
      CMD_CLEAR:  op_dec = OP_CLEAR;
      default:    op_dec = OP_NOP;
    endcase
  end

  assign in_ch.ready = !hold_valid_r || push_ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign push_valid  = hold_valid_r;
  assign push_item   = hold_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_fire) begin
      hold_valid_r <= 1'b1;
    end else if (push_ready) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_item_r.op   <= op_dec;
      hold_item_r.data <= in_ch.data_in;
    end
  end

endmodule

// ----- rtl/urtb_queue.sv -----
`timescale 1ns / 1ps
// urtb_queue: short fifo of decoded requests between front and back end
// depends on urtb_pkg
module urtb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  urtb_pkg::item_t push_item,
  input  logic            push_valid,
  output logic            push_ready,
  output urtb_pkg::item_t pop_item,
  output logic            pop_valid,
  input  logic            pop_ready
);
  import urtb_pkg::*;

  item_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0]  wr_ptr_r;
  logic [QUEUE_PW-1:0]  rd_ptr_r;
  logic [QUEUE_CW-1:0]  cnt_r;
  logic                 push_fire;
  logic                 pop_fire;

  assign push_ready = (cnt_r != QUEUE_CW'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  function automatic logic [QUEUE_PW-1:0] ptr_inc(input logic [QUEUE_PW-1:0] p);
    return (p == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop_fire) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push_fire && !pop_fire) begin
        cnt_r <= cnt_r + QUEUE_CW'(1);
      end else if (pop_fire && !push_fire) begin
        cnt_r <= cnt_r - QUEUE_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == QUEUE_CW'(QUEUE_DEPTH)) && !pop_fire |=> cnt_r == QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue lost an entry while full");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with empty count");

endmodule

// ----- rtl/urtb_back.sv -----
`timescale 1ns / 1ps
// urtb_back: executes operations on the transmit and receive rings and
// drives the result register; depends on urtb_pkg and urtb_ifs
module urtb_back (
  input  logic            clk,
  input  logic            rst_n,
  input  urtb_pkg::item_t pop_item,
  input  logic            pop_valid,
  output logic            pop_ready,
  urtb_out_if.source      out_ch
);
  import urtb_pkg::*;

  localparam logic S_EXEC = 1'b0;
  localparam logic S_FIN  = 1'b1;

  logic [DATA_W-1:0] tx_mem [TX_DEPTH];
  logic [DATA_W-1:0] rx_mem [RX_DEPTH];

  logic    state_r;
  tx_idx_t tx_wr_r, tx_wr_nxt, tx_rd_r, tx_rd_nxt;
  rx_idx_t rx_wr_r, rx_wr_nxt, rx_rd_r, rx_rd_nxt;
  logic    tx_idle_r, tx_idle_nxt;

  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic              send_r, send_nxt;
  logic              bypass_r, bypass_nxt;
  logic              get_r, get_nxt;
  logic              tx_we, rx_we;
  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] tx_q_r, rx_q_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_stat_r;
  logic [DATA_W-1:0] out_read_r;
  logic              out_send_r;
  logic [DATA_W-1:0] out_byte_r;
  logic [LVL_W-1:0]  out_txl_r, out_rxl_r;

  logic [TX_PW:0] tx_cnt;
  logic [RX_PW:0] rx_cnt;
  logic           pop_fire;
  logic           out_load;

  assign tx_cnt    = tx_count(tx_wr_r, tx_rd_r);
  assign rx_cnt    = rx_count(rx_wr_r, rx_rd_r);
  assign pop_ready = (state_r == S_EXEC);
  assign pop_fire  = pop_valid && pop_ready;
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    tx_wr_nxt   = tx_wr_r;
    tx_rd_nxt   = tx_rd_r;
    rx_wr_nxt   = rx_wr_r;
    rx_rd_nxt   = rx_rd_r;
    tx_idle_nxt = tx_idle_r;
    stat_nxt    = STAT_OK;
    send_nxt    = 1'b0;
    bypass_nxt  = 1'b0;
    get_nxt     = 1'b0;
    tx_we       = 1'b0;
    rx_we       = 1'b0;
    unique case (pop_item.op)
      OP_PUT: begin
        if (tx_cnt >= (TX_PW + 1)'(TX_DEPTH - TX_SPARE)) begin
          stat_nxt = STAT_TX_FULL;
        end else begin
          tx_we     = 1'b1;
          tx_wr_nxt = tx_inc(tx_wr_r);
          if (tx_idle_r) begin
            tx_idle_nxt = 1'b0;
            send_nxt    = 1'b1;
            bypass_nxt  = (tx_cnt == '0);
            tx_rd_nxt   = tx_inc(tx_rd_r);
          end
        end
      end
      OP_GET: begin
        if (rx_cnt == '0) begin
          stat_nxt = STAT_RX_EMPTY;
        end else begin
          get_nxt   = 1'b1;
          rx_rd_nxt = rx_inc(rx_rd_r);
        end
      end
      OP_RECV: begin
        if (rx_cnt < (RX_PW + 1)'(RX_DEPTH)) begin
          rx_we     = 1'b1;
          rx_wr_nxt = rx_inc(rx_wr_r);
        end else begin
          stat_nxt = STAT_RX_OVF;
        end
      end
      OP_TXDONE: begin
        if (tx_cnt != '0) begin
          send_nxt  = 1'b1;
          tx_rd_nxt = tx_inc(tx_rd_r);
        end else begin
          tx_idle_nxt = 1'b1;
        end
      end
      OP_CLEAR: begin
        tx_wr_nxt   = '0;
        tx_rd_nxt   = '0;
        rx_wr_nxt   = '0;
        rx_rd_nxt   = '0;
        tx_idle_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_EXEC;
      tx_wr_r     <= '0;
      tx_rd_r     <= '0;
      rx_wr_r     <= '0;
      rx_rd_r     <= '0;
      tx_idle_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (pop_fire) begin
        state_r   <= S_FIN;
        tx_wr_r   <= tx_wr_nxt;
        tx_rd_r   <= tx_rd_nxt;
        rx_wr_r   <= rx_wr_nxt;
        rx_rd_r   <= rx_rd_nxt;
        tx_idle_r <= tx_idle_nxt;
      end else if (out_load) begin
        state_r <= S_EXEC;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ring stores, read-before-write
  always_ff @(posedge clk) begin
    if (pop_fire) begin
      tx_q_r <= tx_mem[tx_slot(tx_rd_r)];
      rx_q_r <= rx_mem[rx_slot(rx_rd_r)];
      if (tx_we) begin
        tx_mem[tx_slot(tx_wr_r)] <= pop_item.data;
      end
      if (rx_we) begin
        rx_mem[rx_slot(rx_wr_r)] <= pop_item.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      stat_r   <= stat_nxt;
      send_r   <= send_nxt;
      bypass_r <= bypass_nxt;
      get_r    <= get_nxt;
      data_r   <= pop_item.data;
    end
    if (out_load) begin
      out_stat_r <= stat_r;
      out_read_r <= get_r ? rx_q_r : '0;
      out_send_r <= send_r;
      out_byte_r <= send_r ? (bypass_r ? data_r : tx_q_r) : '0;
      out_txl_r  <= LVL_W'(tx_cnt);
      out_rxl_r  <= LVL_W'(rx_cnt);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_stat_r;
  assign out_ch.read_data  = out_read_r;
  assign out_ch.send_valid = out_send_r;
  assign out_ch.send_byte  = out_byte_r;
  assign out_ch.tx_level   = out_txl_r;
  assign out_ch.rx_level   = out_rxl_r;

  a_tx_level: assert property (@(posedge clk) disable iff (!rst_n)
    tx_cnt <= (TX_PW + 1)'(TX_DEPTH - TX_SPARE))
    else $error("transmit ring over its put limit");

  a_rx_level: assert property (@(posedge clk) disable iff (!rst_n)
    rx_cnt <= (RX_PW + 1)'(RX_DEPTH))
    else $error("receive ring over depth");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    tx_idle_r |-> (tx_cnt == '0))
    else $error("transmitter idle with bytes queued");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    pop_fire && (pop_item.op == OP_CLEAR) |=> (tx_cnt == '0) && (rx_cnt == '0))
    else $error("clear left bytes in a ring");

endmodule

// ----- rtl/uart_tx_rx_ring_buffers_top.sv -----
`timescale 1ns / 1ps
// uart_tx_rx_ring_buffers_top: serial port transmit and receive ring buffers
// depends on urtb_pkg, urtb_ifs, urtb_front, urtb_queue, urtb_back
//
// in_ch carries one request per handshake: command (put, get, line byte
// received, line transmit done, clear) and data_in. out_ch returns exactly
// one result per request: status, read_data, send_valid/send_byte for the
// line transmitter, and both ring levels after the request.
// the back end handles each request as an execute step and then a result
// load after the registered store read, and takes no new request until
// that result is loaded.
// the front register and a two-entry queue decouple intake from execution;
// when out_ch stalls, the result register holds, the back end waits, and
// in_ch keeps taking requests until the queue and front register are full.
// reset (rst_n low, synchronous) empties both rings, idles the transmitter
// and drops anything in flight; no clearing pass is needed.
module uart_tx_rx_ring_buffers_top (
  input  logic       clk,
  input  logic       rst_n,
  urtb_in_if.sink    in_ch,
  urtb_out_if.source out_ch
);
  import urtb_pkg::*;

  item_t push_item, pop_item;
  logic  push_valid, push_ready;
  logic  pop_valid, pop_ready;

  urtb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  urtb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_item  (push_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  urtb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_item  (pop_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

// ----- tb/urtb_ring_check_pkg.sv -----
`timescale 1ns / 1ps
// ring_tracker: predicts the serial port ring buffers and checks each result
// depends on urtb_pkg for codes, widths and ring index types
package urtb_ring_check_pkg;
  import urtb_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] read_data;
    logic              send_valid;
    logic [DATA_W-1:0] send_byte;
    logic [LVL_W-1:0]  tx_level;
    logic [LVL_W-1:0]  rx_level;
  } result_t;

  class ring_tracker;
    logic [DATA_W-1:0] tx_ring [TX_DEPTH];
    logic [DATA_W-1:0] rx_ring [RX_DEPTH];
    tx_idx_t tx_wr, tx_rd;
    rx_idx_t rx_wr, rx_rd;
    bit      tx_idle;
    result_t pending_results [$];
    int      mismatches;
    int      checked;

    function new();
      tx_wr = '0;
      tx_rd = '0;
      rx_wr = '0;
      rx_rd = '0;
      tx_idle = 1'b1;
      mismatches = 0;
      checked = 0;
    endfunction

    function int tx_fill();
      return (int'(tx_wr) - int'(tx_rd) + 2 * TX_DEPTH) % (2 * TX_DEPTH);
    endfunction

    function int rx_fill();
      return (int'(rx_wr) - int'(rx_rd) + 2 * RX_DEPTH) % (2 * RX_DEPTH);
    endfunction

    function logic [DATA_W-1:0] take_tx_byte();
      logic [DATA_W-1:0] b;
      b = tx_ring[int'(tx_rd) % TX_DEPTH];
      tx_rd = tx_idx_t'((int'(tx_rd) + 1) % (2 * TX_DEPTH));
      return b;
    endfunction

    // advance the ring state by one request and queue what the block must return
    function void note_request(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] data);
      result_t r;
      r = '0;
      r.status = STAT_OK;
      case (cmd)
        CMD_PUT: begin
          if (TX_DEPTH - tx_fill() <= TX_SPARE) begin
            r.status = STAT_TX_FULL;
          end else begin
            tx_ring[int'(tx_wr) % TX_DEPTH] = data;
            tx_wr = tx_idx_t'((int'(tx_wr) + 1) % (2 * TX_DEPTH));
            if (tx_idle) begin
              tx_idle = 1'b0;
              r.send_valid = 1'b1;
              r.send_byte = take_tx_byte();
            end
          end
        end
        CMD_GET: begin
          if (rx_fill() == 0) begin
            r.status = STAT_RX_EMPTY;
          end else begin
            r.read_data = rx_ring[int'(rx_rd) % RX_DEPTH];
            rx_rd = rx_idx_t'((int'(rx_rd) + 1) % (2 * RX_DEPTH));
          end
        end
        CMD_RECV: begin
          if (rx_fill() < RX_DEPTH) begin
            rx_ring[int'(rx_wr) % RX_DEPTH] = data;
            rx_wr = rx_idx_t'((int'(rx_wr) + 1) % (2 * RX_DEPTH));
          end else begin
            r.status = STAT_RX_OVF;
          end
        end
        CMD_TXDONE: begin
          if (tx_fill() != 0) begin
            r.send_valid = 1'b1;
            r.send_byte = take_tx_byte();
          end else begin
            tx_idle = 1'b1;
          end
        end
        CMD_CLEAR: begin
          tx_wr = '0;
          tx_rd = '0;
          rx_wr = '0;
          rx_rd = '0;
          tx_idle = 1'b1;
        end
        default: begin
        end
      endcase
      r.tx_level = LVL_W'(tx_fill());
      r.rx_level = LVL_W'(rx_fill());
      pending_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      bit bad;
      checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d unexpected: st=%0d rd=%02h sv=%0d sb=%02h tx=%0d rx=%0d",
                   checked, got.status, got.read_data, got.send_valid, got.send_byte,
                   got.tx_level, got.rx_level);
        end
        return;
      end
      want = pending_results.pop_front();
      bad = (got.status !== want.status) || (got.read_data !== want.read_data) ||
            (got.send_valid !== want.send_valid) || (got.send_byte !== want.send_byte) ||
            (got.tx_level !== want.tx_level) || (got.rx_level !== want.rx_level);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d expected st=%0d rd=%02h sv=%0d sb=%02h tx=%0d rx=%0d",
                   checked, want.status, want.read_data, want.send_valid, want.send_byte,
                   want.tx_level, want.rx_level);
          $display("result %0d actual   st=%0d rd=%02h sv=%0d sb=%02h tx=%0d rx=%0d",
                   checked, got.status, got.read_data, got.send_valid, got.send_byte,
                   got.tx_level, got.rx_level);
        end
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: random and directed requests against the serial port ring buffers
// depends on urtb_pkg, urtb_ifs, urtb_ring_check_pkg and the block's rtl
module tb_top;
  import urtb_pkg::*;
  import urtb_ring_check_pkg::*;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;

  urtb_in_if  in_ch ();
  urtb_out_if out_ch ();

  ring_tracker sb;

  uart_tx_rx_ring_buffers_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_request(in_ch.command, in_ch.data_in);
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status     = out_ch.status;
      got.read_data  = out_ch.read_data;
      got.send_valid = out_ch.send_valid;
      got.send_byte  = out_ch.send_byte;
      got.tx_level   = out_ch.tx_level;
      got.rx_level   = out_ch.rx_level;
      sb.check_result(got);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.data_in <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [CMD_W-1:0] pick_command(input mix_t mix);
    int roll;
    roll = $urandom_range(99);
    if (roll < 1) return CMD_CLEAR;
    if (roll < 3) return CMD_W'($urandom_range(7, 5));
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        if (roll < 45) return CMD_PUT;
        if (roll < 90) return CMD_RECV;
        if (roll < 95) return CMD_GET;
        return CMD_TXDONE;
      end
      MIX_DRAIN: begin
        if (roll < 8) return CMD_PUT;
        if (roll < 16) return CMD_RECV;
        if (roll < 58) return CMD_GET;
        return CMD_TXDONE;
      end
      default: begin
        if (roll < 25) return CMD_PUT;
        if (roll < 50) return CMD_RECV;
        if (roll < 75) return CMD_GET;
        return CMD_TXDONE;
      end
    endcase
  endfunction

  task automatic random_phase(input int count);
    mix_t mix;
    int   left_in_mix;
    left_in_mix = 0;
    mix = MIX_EVEN;
    for (int i = 0; i < count; i++) begin
      if (left_in_mix == 0) begin
        mix = mix_t'($urandom_range(2));
        left_in_mix = $urandom_range(60, 20);
      end
      left_in_mix--;
      send_request(pick_command(mix), DATA_W'($urandom_range(255)));
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_PUT;
    in_ch.data_in = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corner cases
    send_request(CMD_TXDONE, 8'h00);
    send_request(CMD_GET, 8'hff);
    send_request(3'd5, 8'h5a);
    send_request(3'd6, 8'ha5);
    send_request(3'd7, 8'hff);
    send_request(CMD_PUT, 8'h00);
    send_request(CMD_PUT, 8'hff);
    send_request(CMD_PUT, 8'h5a);
    send_request(CMD_TXDONE, 8'h00);
    send_request(CMD_TXDONE, 8'h00);
    send_request(CMD_TXDONE, 8'h00);
    send_request(CMD_TXDONE, 8'h00);
    send_request(CMD_RECV, 8'h00);
    send_request(CMD_RECV, 8'hff);
    send_request(CMD_RECV, 8'ha5);
    send_request(CMD_GET, 8'h00);
    send_request(CMD_GET, 8'h00);
    send_request(CMD_PUT, 8'h3c);
    send_request(CMD_RECV, 8'hc3);
    send_request(CMD_CLEAR, 8'h00);
    send_request(CMD_GET, 8'h00);
    send_request(CMD_TXDONE, 8'h00);
    wait_results_drained();

    send_idle_pct = 14;
    recv_idle_pct = 68;
    random_phase(260);
    wait_results_drained();

    send_idle_pct = 68;
    recv_idle_pct = 14;
    random_phase(260);
    wait_results_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(260);

    wait_results_drained();
    repeat (20) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/urtb_pkg.sv
rtl/urtb_ifs.sv
rtl/urtb_front.sv
rtl/urtb_queue.sv
rtl/urtb_back.sv
rtl/uart_tx_rx_ring_buffers_top.sv
tb/urtb_ring_check_pkg.sv
tb/tb_top.sv
